[hw/rtl/sfr_pkg.sv]
// Shared types and constants for the streaming find-and-replace block.
`default_nettype none

package sfr_pkg;

  // Largest pattern and replacement, in bytes.
  localparam int MAX_PATTERN = 8;
  localparam int MAX_REPLACE = 8;

  // Bytes one input transaction can cause on the output.
  localparam int RUN_MAX = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE;

  // Width of a length register and of a run byte count (holds RUN_MAX).
  localparam int LEN_W = 4;
  // Width of a position inside the window or a run.
  localparam int PTR_W = 3;

  // Line break that flushes the window.
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

  // A row of bytes, byte 0 in bits 7 to 0.
  typedef logic [RUN_MAX-1:0][7:0] byte_vec_t;

  // The output bytes that one input transaction causes.
  typedef struct packed {
    byte_vec_t         bytes;
    logic [LEN_W-1:0]  cnt;
    logic              stream_end;
  } run_t;

  // Window status seen by the top-level checks.
  typedef struct packed {
    logic [PTR_W-1:0] pend_cnt;
    logic [LEN_W-1:0] len_eff;
  } sfr_status_t;

endpackage

`default_nettype wire

[hw/rtl/sfr_in_if.sv]
// Input channel interface: text byte with stream-end mark.
`default_nettype none

interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

`default_nettype wire

[hw/rtl/sfr_out_if.sv]
// Output channel interface: rewritten byte with run and stream markers.
`default_nettype none

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;

  modport source (output valid, output out_byte, output run_last, output stream_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_done,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/stream_find_replace.sv]
// Top level of the streaming find-and-replace block.
// The block takes one text byte per cycle while in_ready is high and rewrites
// every leftmost, non-overlapping occurrence of the configured pattern (1 to
// 8 bytes) with the replacement (0 to 8 bytes); a newline or a stream-end
// mark flushes the held bytes, so matches never span lines. An input is
// decided in the cycle it is accepted; its output bytes (0 to 8) go via the
// stage and active run registers to the single output port, one byte per
// cycle while it is ready. A two-run buffer keeps input flowing at one byte
// per cycle while runs are one byte long and the output is ready; longer
// runs (a replacement, a flush) stall the input for their extra bytes.
// Write configuration only while the block is idle.
`default_nettype none

module stream_find_replace (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  sfr_in_if.sink                               in_s,
  sfr_out_if.source                            out_m,
  input  wire logic                            cfg_we,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  sfr_pkg::run_t        run;
  logic                 run_valid;
  logic                 in_ready;
  logic                 in_accept;
  sfr_pkg::sfr_status_t status;

  assign in_s.ready = in_ready;
  assign in_accept  = in_s.valid && in_ready;

  // Window and match logic.
  sfr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_accept  (in_accept),
    .in_byte    (in_s.in_byte),
    .stream_end (in_s.stream_end),
    .run        (run),
    .run_valid  (run_valid),
    .status     (status)
  );

  // Output serializer.
  sfr_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_valid (run_valid),
    .run       (run),
    .in_ready  (in_ready),
    .out_m     (out_m)
  );

`ifndef SYNTH
  // A stream-end transaction leaves the window empty.
  a_end_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_s.stream_end && !cfg_we) |=> (status.pend_cnt == '0))
    else $error("window not empty after stream end");

  // Writing the pattern length discards the window.
  a_len_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == sfr_pkg::CFG_PATTERN_LENGTH)) |=> (status.pend_cnt == '0))
    else $error("window kept after pattern length write");

  // The window never holds a whole pattern between transactions.
  a_window_short: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, status.pend_cnt} < status.len_eff))
    else $error("window count reached pattern length");
`endif

endmodule

`default_nettype wire

[hw/rtl/sfr_core.sv]
// Configuration registers, pending window and per-byte match logic.
`default_nettype none

module sfr_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_accept,
  input  wire logic [7:0]                      in_byte,
  input  wire logic                            stream_end,
  output sfr_pkg::run_t                        run,
  output logic                                 run_valid,
  output sfr_pkg::sfr_status_t                 status
);

  sfr_pkg::byte_vec_t               pat_r;
  logic [sfr_pkg::LEN_W-1:0]        pat_len_r;
  sfr_pkg::byte_vec_t               rep_r;
  logic [sfr_pkg::LEN_W-1:0]        rep_len_r;
  sfr_pkg::byte_vec_t               win_r;
  sfr_pkg::byte_vec_t               win_nxt;
  logic [sfr_pkg::PTR_W-1:0]        cnt_r;
  logic [sfr_pkg::PTR_W-1:0]        cnt_nxt;

  logic [sfr_pkg::LEN_W-1:0]        len_eff;
  logic [sfr_pkg::LEN_W-1:0]        rep_eff;
  logic [sfr_pkg::PTR_W-1:0]        slot;
  logic [sfr_pkg::LEN_W-1:0]        fill;
  sfr_pkg::byte_vec_t               win_ins;
  sfr_pkg::byte_vec_t               win_sh;
  logic                             full;
  logic                             eq;
  logic                             matched;
  logic                             flush;
  logic [sfr_pkg::LEN_W-1:0]        pass_cnt;

  // Clamp the length registers to their legal ranges.
  always_comb begin
    if (pat_len_r == '0) begin
      len_eff = sfr_pkg::LEN_W'(1);
    end else if (pat_len_r > sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN)) begin
      len_eff = sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN);
    end else begin
      len_eff = pat_len_r;
    end
    if (rep_len_r > sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACE)) begin
      rep_eff = sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACE);
    end else begin
      rep_eff = rep_len_r;
    end
  end

  // Insert the new byte, compare the full window, and decide what leaves.
  always_comb begin
    if ({1'b0, cnt_r} >= len_eff) begin
      slot = sfr_pkg::PTR_W'(len_eff - sfr_pkg::LEN_W'(1));
    end else begin
      slot = cnt_r;
    end
    fill = {1'b0, slot} + sfr_pkg::LEN_W'(1);

    for (int i = 0; i < sfr_pkg::RUN_MAX; i++) begin
      win_ins[i] = (sfr_pkg::PTR_W'(i) == slot) ? in_byte : win_r[i];
    end

    // Window after the oldest byte is passed on.
    for (int i = 0; i < sfr_pkg::RUN_MAX - 1; i++) begin
      win_sh[i] = win_ins[i+1];
    end
    win_sh[sfr_pkg::RUN_MAX-1] = win_ins[sfr_pkg::RUN_MAX-1];

    eq = 1'b1;
    for (int i = 0; i < sfr_pkg::RUN_MAX; i++) begin
      if ((sfr_pkg::LEN_W'(i) < len_eff) && (win_ins[i] != pat_r[i])) begin
        eq = 1'b0;
      end
    end

    full    = (fill == len_eff);
    matched = full && eq;
    flush   = (!matched && (in_byte == sfr_pkg::NEWLINE_BYTE)) || stream_end;

    // Without a match the output is always a prefix of the window.
    if (flush) begin
      pass_cnt = fill;
    end else if (full) begin
      pass_cnt = sfr_pkg::LEN_W'(1);
    end else begin
      pass_cnt = '0;
    end

    run.bytes      = matched ? rep_r : win_ins;
    run.cnt        = matched ? rep_eff : pass_cnt;
    run.stream_end = stream_end;
    run_valid      = in_accept && (run.cnt != '0);

    win_nxt = (full && !matched) ? win_sh : win_ins;
    if (matched || flush) begin
      cnt_nxt = '0;
    end else if (full) begin
      cnt_nxt = sfr_pkg::PTR_W'(len_eff - sfr_pkg::LEN_W'(1));
    end else begin
      cnt_nxt = sfr_pkg::PTR_W'(fill);
    end
  end

  // Configuration registers and window state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r     <= '0;
      pat_len_r <= sfr_pkg::LEN_W'(1);
      rep_r     <= '0;
      rep_len_r <= '0;
      cnt_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfr_pkg::CFG_PATTERN_BYTES: begin
          pat_r <= sfr_pkg::byte_vec_t'(cfg_wdata);
        end
        sfr_pkg::CFG_PATTERN_LENGTH: begin
          pat_len_r <= cfg_wdata[sfr_pkg::LEN_W-1:0];
          cnt_r     <= '0;
        end
        sfr_pkg::CFG_REPLACEMENT_BYTES: begin
          rep_r <= sfr_pkg::byte_vec_t'(cfg_wdata);
        end
        sfr_pkg::CFG_REPLACEMENT_LENGTH: begin
          rep_len_r <= cfg_wdata[sfr_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (in_accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Window bytes carry no reset; the count says which are live.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      win_r <= win_nxt;
    end
  end

  assign status.pend_cnt = cnt_r;
  assign status.len_eff  = len_eff;

endmodule

`default_nettype wire

[hw/rtl/sfr_emit.sv]
// Two-run buffer that serializes run bytes onto the output channel.
`default_nettype none

module sfr_emit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          run_valid,
  input  wire sfr_pkg::run_t run,
  output logic               in_ready,
  sfr_out_if.source          out_m
);

  logic                        stg_v_r;
  sfr_pkg::run_t               stg_r;
  sfr_pkg::run_t               act_r;
  logic [sfr_pkg::LEN_W-1:0]   act_left_r;
  logic [sfr_pkg::PTR_W-1:0]   act_idx_r;

  logic fire;
  logic act_free;
  logic move;
  logic last;

  // The active run frees up when it is empty or its final byte leaves now.
  always_comb begin
    last     = (act_left_r == sfr_pkg::LEN_W'(1));
    fire     = (act_left_r != '0) && out_m.ready;
    act_free = (act_left_r == '0) || (last && out_m.ready);
    move     = stg_v_r && act_free;
    in_ready = !stg_v_r || act_free;
  end

  // Stage and active run registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r    <= 1'b0;
      act_left_r <= '0;
      act_idx_r  <= '0;
    end else begin
      if (move) begin
        act_left_r <= stg_r.cnt;
        act_idx_r  <= '0;
      end else if (fire) begin
        act_left_r <= act_left_r - sfr_pkg::LEN_W'(1);
        act_idx_r  <= act_idx_r + sfr_pkg::PTR_W'(1);
      end
      if (!stg_v_r || move) begin
        stg_v_r <= run_valid;
      end
    end
  end

  // Run payloads need no reset.
  always_ff @(posedge clk) begin
    if (move) begin
      act_r <= stg_r;
    end
    if (!stg_v_r || move) begin
      stg_r <= run;
    end
  end

  // Output transaction fields come straight from the active run.
  assign out_m.valid       = (act_left_r != '0);
  assign out_m.out_byte    = act_r.bytes[act_idx_r];
  assign out_m.run_last    = last;
  assign out_m.stream_done = last && act_r.stream_end;

endmodule

`default_nettype wire
